@@ sv/khop_pkg.sv @@
// Shared sizes and codes for the k-hop neighborhood connector.
package khop_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERT_W       = 6;
  localparam int DATA_W       = 64;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int HOP_W        = 6;
  localparam int HOP_CNT_W    = HOP_W + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [DATA_W-1:0] VMASK = {DATA_W{1'b1}} >> (DATA_W - MAX_VERTICES);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] MODE_OUT = 2'd0;
  localparam logic [1:0] MODE_IN  = 2'd1;
  localparam logic [1:0] MODE_ALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 2'd1;

  localparam logic [HOP_W-1:0] HOP_LIMIT_RST = 6'd2;

endpackage

@@ sv/khop_neighborhood_connect.sv @@
// Top level: adjacency matrix in row and column memories with bounded BFS query.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------------
//   in_     | in  | in_valid/in_ready   | operation, vertex_a, vertex_b
//   out_    | out | out_valid/out_ready | source_vertex, new_targets
//   cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
//
// Add accepts, reads the row and column words, then writes them back; clear
// accepts, then drops all valid flags. A query fetches the source row, then
// per hop reads one memory word per frontier vertex, then closes the search
// and loads the output register. A hop limit below 2 skips the search.
// Reset clears the row/column valid flags: the graph is empty at once; no sweep.
// A result waits in the output register; a stalled result halts the next query in S_DONE.
module khop_neighborhood_connect (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [khop_pkg::VERT_W-1:0]        in_vertex_a,
  input  logic [khop_pkg::VERT_W-1:0]        in_vertex_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [khop_pkg::VERT_W-1:0]        out_source_vertex,
  output logic [khop_pkg::DATA_W-1:0]        out_new_targets,
  input  logic                               cfg_we,
  input  logic [khop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [khop_pkg::HOP_W-1:0]         cfg_wdata
);

  localparam int DW = khop_pkg::DATA_W;
  localparam int AW = khop_pkg::ADDR_W;
  localparam int NV = khop_pkg::MAX_VERTICES;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_CLEAR, S_Q_SRC, S_Q_NBR, S_HOP, S_EXP, S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [1:0]                    op_r, op_nxt;
  logic [khop_pkg::VERT_W-1:0]   va_r, va_nxt, vb_r, vb_nxt;
  logic [khop_pkg::HOP_W-1:0]    hop_limit_r, hop_limit_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic [NV-1:0]                 rv_r, rv_nxt, cv_r, cv_nxt;
  logic [DW-1:0]                 frontier_r, frontier_nxt;
  logic [DW-1:0]                 visited_r, visited_nxt;
  logic [DW-1:0]                 found_r, found_nxt;
  logic [DW-1:0]                 acc_r, acc_nxt;
  logic [khop_pkg::HOP_CNT_W-1:0] hop_r, hop_nxt;
  logic                          pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [khop_pkg::VERT_W-1:0]   out_src_r, out_src_nxt;
  logic [DW-1:0]                 out_tgt_r, out_tgt_nxt;

  // memories and registered read ports
  logic [DW-1:0] row_mem [NV];
  logic [DW-1:0] col_mem [NV];
  logic [DW-1:0] row_q, col_q;
  logic          row_qv, col_qv;
  logic [AW-1:0] row_ra, col_ra;
  logic          mem_we;
  logic [DW-1:0] row_wd, col_wd;

  logic [DW-1:0] row_d, col_d, nbrs;
  logic [DW-1:0] lowbit, next_set, final_mask;
  logic [AW-1:0] low_idx;
  logic          va_ok, vb_ok;

  function automatic logic [AW-1:0] onehot_idx(input logic [DW-1:0] oh);
    logic [AW-1:0] idx;
    idx = '0;
    for (int j = 0; j < NV; j++) begin
      if (oh[j]) idx = idx | AW'(j);
    end
    return idx;
  endfunction

  assign va_ok = ({1'b0, va_r} < (khop_pkg::VERT_W + 1)'(NV));
  assign vb_ok = ({1'b0, vb_r} < (khop_pkg::VERT_W + 1)'(NV));

  assign row_d = row_qv ? row_q : '0;
  assign col_d = col_qv ? col_q : '0;

  always_comb begin
    case (mode_r)
      khop_pkg::MODE_IN:  nbrs = col_d & khop_pkg::VMASK;
      khop_pkg::MODE_ALL: nbrs = (row_d | col_d) & khop_pkg::VMASK;
      default:            nbrs = row_d & khop_pkg::VMASK;
    endcase
  end

  // lowest pending frontier vertex
  assign lowbit   = frontier_r & (~frontier_r + DW'(1));
  assign low_idx  = onehot_idx(lowbit);
  assign next_set = acc_r & ~visited_r;

  // in undirected mode only targets above the source are reported
  assign final_mask = ((mode_r == khop_pkg::MODE_ALL)
                       ? (found_r & ~((DW'(2) << va_r) - DW'(1)))
                       : found_r) & khop_pkg::VMASK;

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_source_vertex = out_src_r;
  assign out_new_targets   = out_tgt_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    hop_limit_nxt = hop_limit_r;
    mode_nxt      = mode_r;
    rv_nxt        = rv_r;
    cv_nxt        = cv_r;
    frontier_nxt  = frontier_r;
    visited_nxt   = visited_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    hop_nxt       = hop_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_src_nxt   = out_src_r;
    out_tgt_nxt   = out_tgt_r;
    row_ra        = va_r[AW-1:0];
    col_ra        = va_r[AW-1:0];
    mem_we        = 1'b0;
    row_wd        = row_d | (DW'(1) << vb_r);
    col_wd        = col_d | (DW'(1) << va_r);

    if (cfg_we) begin
      case (cfg_index)
        khop_pkg::CFG_HOP_LIMIT:   hop_limit_nxt = cfg_wdata;
        khop_pkg::CFG_SEARCH_MODE: mode_nxt      = cfg_wdata[1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          va_nxt = in_vertex_a;
          vb_nxt = in_vertex_b;
          case (in_operation)
            khop_pkg::OP_ADD:   state_nxt = S_ADD_RD;
            khop_pkg::OP_CLEAR: state_nxt = S_CLEAR;
            khop_pkg::OP_QUERY: state_nxt = S_Q_SRC;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        row_ra    = va_r[AW-1:0];
        col_ra    = vb_r[AW-1:0];
        state_nxt = (va_ok && vb_ok) ? S_ADD_WR : S_IDLE;
      end
      S_ADD_WR: begin
        mem_we               = 1'b1;
        rv_nxt[va_r[AW-1:0]] = 1'b1;
        cv_nxt[vb_r[AW-1:0]] = 1'b1;
        state_nxt            = S_IDLE;
      end
      S_CLEAR: begin
        rv_nxt    = '0;
        cv_nxt    = '0;
        state_nxt = S_IDLE;
      end
      S_Q_SRC: begin
        found_nxt = '0;
        state_nxt = (!va_ok || hop_limit_r < khop_pkg::HOP_W'(2)) ? S_DONE : S_Q_NBR;
      end
      S_Q_NBR: begin
        visited_nxt  = (DW'(1) << va_r) | nbrs;
        frontier_nxt = nbrs;
        hop_nxt      = khop_pkg::HOP_CNT_W'(2);
        state_nxt    = S_HOP;
      end
      S_HOP: begin
        if (hop_r > {1'b0, hop_limit_r} || frontier_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (pend_r) acc_nxt = acc_r | nbrs;
        if (frontier_r != '0) begin
          row_ra       = low_idx;
          col_ra       = low_idx;
          frontier_nxt = frontier_r & (frontier_r - DW'(1));
          pend_nxt     = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          // hop complete: newly reached vertices form the next frontier
          visited_nxt  = visited_r | next_set;
          found_nxt    = found_r | next_set;
          frontier_nxt = next_set;
          hop_nxt      = hop_r + khop_pkg::HOP_CNT_W'(1);
          state_nxt    = S_HOP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = va_r;
          out_tgt_nxt   = final_mask;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hop_limit_r <= khop_pkg::HOP_LIMIT_RST;
      mode_r      <= khop_pkg::MODE_OUT;
      rv_r        <= '0;
      cv_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hop_limit_r <= hop_limit_nxt;
      mode_r      <= mode_nxt;
      rv_r        <= rv_nxt;
      cv_r        <= cv_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    frontier_r <= frontier_nxt;
    visited_r  <= visited_nxt;
    found_r    <= found_nxt;
    acc_r      <= acc_nxt;
    hop_r      <= hop_nxt;
    out_src_r  <= out_src_nxt;
    out_tgt_r  <= out_tgt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[va_r[AW-1:0]] <= row_wd;
      col_mem[vb_r[AW-1:0]] <= col_wd;
    end
    row_q  <= row_mem[row_ra];
    col_q  <= col_mem[col_ra];
    row_qv <= rv_r[row_ra];
    col_qv <= cv_r[col_ra];
  end

  // frontier is always a subset of the visited set during expansion
  a_frontier_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOP || state_r == S_EXP) |-> ((frontier_r & ~visited_r) == '0))
    else $error("frontier holds unvisited vertex");

  // the source itself is never among the found vertices
  a_src_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOP || state_r == S_EXP) |-> !found_r[va_r])
    else $error("source vertex reported as target");

  // expansion never runs past the hop limit
  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXP) |-> (hop_r <= {1'b0, hop_limit_r}))
    else $error("expansion beyond hop limit");

  // a result is only produced by a finished query
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE && $past(op_r) == khop_pkg::OP_QUERY))
    else $error("result without query");

endmodule
